@@ hw/rtl/tsgr_pkg.sv @@
// ----------------------------------------------------------------------------
// Touch stroke grid rasterizer package
// Shared constants, field widths, item codes and the controller/datapath
// command and status structures.
// ----------------------------------------------------------------------------
package tsgr_pkg;

  // Default geometry of the drawing grid and the touch slot count.
  localparam int GridCellsDef  = 28;
  localparam int CellPixelsDef = 12;
  localparam int AreaOriginDef = 72;
  localparam int TouchSlotsDef = 5;

  // Fixed field widths.
  localparam int CoordW   = 10;
  localparam int SlotW    = 3;
  localparam int RowSelW  = 5;
  localparam int RowBitsW = 28;

  // Clear zone: presses above this y line and right of clear_zone_x wipe the grid.
  localparam logic [CoordW-1:0] ClearZoneY      = CoordW'(20);
  localparam logic [CoordW-1:0] ClearZoneXReset = CoordW'(456);

  // Shift used by the reciprocal multiply that turns a pixel offset into a cell.
  localparam int RecipShift = 20;

  // Item codes carried on the action field.
  localparam logic ActionTouch = 1'b0;
  localparam logic ActionRead  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // an item is taken this cycle
    logic setup;   // line setup: deltas and cell quotient products
    logic rem;     // line setup: cells and in-cell offsets
    logic step;    // one line pixel is marked
  } tsgr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic draw;    // the item on the inputs starts a line
    logic last;    // the current line pixel is the final one
  } tsgr_stat_t;

endpackage

@@ hw/rtl/tsgr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Touch stroke grid rasterizer controller
// Sequences item acceptance, the line setup states (setup, then rem) and the pixel loop.
// ----------------------------------------------------------------------------
module tsgr_ctrl
  import tsgr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output tsgr_cmd_t  cmd,
  input  tsgr_stat_t stat
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSetup = 2'd1;
  localparam logic [1:0] StRem   = 2'd2;
  localparam logic [1:0] StRun   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      StIdle: begin
        cmd.accept = start;
        if (start && stat.draw) begin
          state_next = StSetup;
        end
      end
      StSetup: begin
        cmd.setup  = 1'b1;
        state_next = StRem;
      end
      StRem: begin
        cmd.rem    = 1'b1;
        state_next = StRun;
      end
      StRun: begin
        cmd.step = 1'b1;
        if (stat.last) begin
          state_next = StIdle;
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != StIdle);

  a_draw_enters_setup: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && stat.draw) |=> (state == StSetup))
    else $error("drawing item did not enter line setup");

  a_setup_to_rem: assert property (@(posedge clk) disable iff (rst)
    (state == StSetup) |=> (state == StRem))
    else $error("line setup did not advance");

  a_run_holds: assert property (@(posedge clk) disable iff (rst)
    (state == StRun && !stat.last) |=> (state == StRun))
    else $error("pixel loop ended before its last pixel");

endmodule

@@ hw/rtl/tsgr_datapath.sv @@
// ----------------------------------------------------------------------------
// Touch stroke grid rasterizer datapath
// Slot table, cell bitmap, clear zone register and the line stepping unit.
// ----------------------------------------------------------------------------
module tsgr_datapath
  import tsgr_pkg::*;
#(
  parameter int GRID_CELLS  = GridCellsDef,
  parameter int CELL_PIXELS = CellPixelsDef,
  parameter int AREA_ORIGIN = AreaOriginDef,
  parameter int TOUCH_SLOTS = TouchSlotsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  tsgr_cmd_t           cmd,
  output tsgr_stat_t          stat,
  input  logic                cfg_wr_en,
  input  logic [CoordW-1:0]   cfg_wr_data,
  input  logic                action,
  input  logic [SlotW-1:0]    slot,
  input  logic                pressed,
  input  logic [CoordW-1:0]   touch_x,
  input  logic [CoordW-1:0]   touch_y,
  input  logic [RowSelW-1:0]  row_select,
  output logic                done,
  output logic [RowSelW-1:0]  row_number,
  output logic [RowBitsW-1:0] row_bits
);

  localparam int AreaEnd  = AREA_ORIGIN + GRID_CELLS * CELL_PIXELS - 1;
  localparam int CellW    = $clog2(GRID_CELLS);
  localparam int OffW     = (CELL_PIXELS > 1) ? $clog2(CELL_PIXELS) : 1;
  localparam int RecipW   = RecipShift + 1;
  localparam int ProdW    = CoordW + RecipW;
  localparam int DistW    = CoordW + 1;
  localparam logic [RecipW-1:0] RecipM =
      RecipW'(((1 << RecipShift) + CELL_PIXELS - 1) / CELL_PIXELS);
  localparam logic [CoordW-1:0] Origin  = CoordW'(AREA_ORIGIN);
  localparam logic [OffW-1:0]   OffLast = OffW'(CELL_PIXELS - 1);

  // Architectural state.
  logic [CoordW-1:0]     clear_zone_x;
  logic [GRID_CELLS-1:0] cell_bitmap [GRID_CELLS];
  logic [CoordW-1:0]     last_point_x [TOUCH_SLOTS];
  logic [CoordW-1:0]     last_point_y [TOUCH_SLOTS];
  logic [TOUCH_SLOTS-1:0] last_point_valid;

  // Line stepping registers.
  logic [CoordW-1:0] x0, y0, x1, y1;
  logic [CoordW-1:0] adx, ady, span_len, ex, ey;
  logic              xneg, yneg;
  logic [ProdW-1:0]  prod_x, prod_y;
  logic [CellW-1:0]  cell_x, cell_y;
  logic [OffW-1:0]   off_x, off_y;
  logic [DistW-1:0]  count;

  // Item decode.
  logic                  slot_hit;
  logic                  sel_valid;
  logic [CoordW-1:0]     sel_x, sel_y;
  logic [GRID_CELLS-1:0] row_pick;
  logic [RowBitsW-1:0]   row_word;
  logic                  is_touch, in_area, clear_hit, draw;

  always_comb begin
    slot_hit  = 1'b0;
    sel_valid = 1'b0;
    sel_x     = '0;
    sel_y     = '0;
    for (int s = 0; s < TOUCH_SLOTS; s++) begin
      if (int'(slot) == s) begin
        slot_hit  = 1'b1;
        sel_valid = last_point_valid[s];
        sel_x     = last_point_x[s];
        sel_y     = last_point_y[s];
      end
    end
  end

  always_comb begin
    row_pick = '0;
    row_word = '0;
    for (int r = 0; r < GRID_CELLS; r++) begin
      if (int'(row_select) == r) begin
        row_pick = cell_bitmap[r];
      end
    end
    for (int i = 0; i < RowBitsW; i++) begin
      if (i < GRID_CELLS) begin
        row_word[i] = row_pick[i];
      end
    end
  end

  assign is_touch  = (action == ActionTouch) && slot_hit;
  assign in_area   = (int'(touch_x) > AREA_ORIGIN) && (int'(touch_x) < AreaEnd) &&
                     (int'(touch_y) > AREA_ORIGIN) && (int'(touch_y) < AreaEnd);
  assign draw      = is_touch && pressed && in_area;
  assign clear_hit = is_touch && pressed && (touch_x > clear_zone_x) &&
                     (touch_y < ClearZoneY);

  assign stat.draw = draw;
  assign stat.last = (count == '0);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_zone_x <= ClearZoneXReset;
    end else if (cfg_wr_en) begin
      clear_zone_x <= cfg_wr_data;
    end
  end

  // Slot table.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_point_valid <= '0;
    end else if (cmd.accept && is_touch) begin
      for (int s = 0; s < TOUCH_SLOTS; s++) begin
        if (int'(slot) == s) begin
          if (!pressed) begin
            last_point_valid[s] <= 1'b0;
          end else if (in_area) begin
            last_point_valid[s] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && draw) begin
      for (int s = 0; s < TOUCH_SLOTS; s++) begin
        if (int'(slot) == s) begin
          last_point_x[s] <= touch_x;
          last_point_y[s] <= touch_y;
        end
      end
    end
  end

  // Read result.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.accept && (action == ActionRead);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (action == ActionRead)) begin
      row_number <= row_select;
      row_bits   <= row_word;
    end
  end

  // Cell bitmap: wiped by reset or a clear zone press, marked one pixel a cycle.
  always_ff @(posedge clk) begin
    if (rst || (cmd.accept && clear_hit)) begin
      for (int r = 0; r < GRID_CELLS; r++) begin
        cell_bitmap[r] <= '0;
      end
    end else if (cmd.step) begin
      cell_bitmap[cell_y][cell_x] <= 1'b1;
    end
  end

  // Line setup and stepping.
  logic [CoordW-1:0] vx, vy;
  logic [CellW-1:0]  qx, qy;
  logic [DistW-1:0]  ex_sum, ey_sum;
  logic              move_x, move_y;
  logic [CellW-1:0]  cell_x_next, cell_y_next;
  logic [OffW-1:0]   off_x_next, off_y_next;

  assign vx     = x0 - Origin;
  assign vy     = y0 - Origin;
  assign qx     = prod_x[RecipShift +: CellW];
  assign qy     = prod_y[RecipShift +: CellW];
  assign ex_sum = {1'b0, ex} + {1'b0, adx};
  assign ey_sum = {1'b0, ey} + {1'b0, ady};
  assign move_x = ex_sum > {1'b0, span_len};
  assign move_y = ey_sum > {1'b0, span_len};

  always_comb begin
    cell_x_next = cell_x;
    off_x_next  = off_x;
    if (move_x) begin
      if (xneg) begin
        if (off_x == '0) begin
          off_x_next  = OffLast;
          cell_x_next = cell_x - CellW'(1);
        end else begin
          off_x_next = off_x - OffW'(1);
        end
      end else begin
        if (off_x == OffLast) begin
          off_x_next  = '0;
          cell_x_next = cell_x + CellW'(1);
        end else begin
          off_x_next = off_x + OffW'(1);
        end
      end
    end
  end

  always_comb begin
    cell_y_next = cell_y;
    off_y_next  = off_y;
    if (move_y) begin
      if (yneg) begin
        if (off_y == '0) begin
          off_y_next  = OffLast;
          cell_y_next = cell_y - CellW'(1);
        end else begin
          off_y_next = off_y - OffW'(1);
        end
      end else begin
        if (off_y == OffLast) begin
          off_y_next  = '0;
          cell_y_next = cell_y + CellW'(1);
        end else begin
          off_y_next = off_y + OffW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && draw) begin
      x0 <= sel_valid ? sel_x : touch_x;
      y0 <= sel_valid ? sel_y : touch_y;
      x1 <= touch_x;
      y1 <= touch_y;
    end
    if (cmd.setup) begin
      prod_x <= ProdW'(vx) * ProdW'(RecipM);
      prod_y <= ProdW'(vy) * ProdW'(RecipM);
      xneg   <= x1 < x0;
      yneg   <= y1 < y0;
      adx    <= (x1 < x0) ? (x0 - x1) : (x1 - x0);
      ady    <= (y1 < y0) ? (y0 - y1) : (y1 - y0);
    end
    if (cmd.rem) begin
      cell_x   <= qx;
      cell_y   <= qy;
      off_x    <= OffW'(vx - CoordW'(int'(qx) * CELL_PIXELS));
      off_y    <= OffW'(vy - CoordW'(int'(qy) * CELL_PIXELS));
      span_len <= (adx > ady) ? adx : ady;
      count    <= {1'b0, ((adx > ady) ? adx : ady)} + DistW'(1);
      ex       <= '0;
      ey       <= '0;
    end
    if (cmd.step) begin
      ex     <= move_x ? CoordW'(ex_sum - {1'b0, span_len}) : ex_sum[CoordW-1:0];
      ey     <= move_y ? CoordW'(ey_sum - {1'b0, span_len}) : ey_sum[CoordW-1:0];
      cell_x <= cell_x_next;
      cell_y <= cell_y_next;
      off_x  <= off_x_next;
      off_y  <= off_y_next;
      count  <= count - DistW'(1);
    end
  end

  a_step_in_grid: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> ((int'(cell_x) < GRID_CELLS) && (int'(cell_y) < GRID_CELLS)))
    else $error("line pixel left the grid");

  a_done_after_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.accept && (action == ActionRead)))
    else $error("result strobe without a read");

  a_err_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> ((ex <= span_len) && (ey <= span_len)))
    else $error("error accumulator out of range");

endmodule

@@ hw/rtl/touch_stroke_grid_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// Touch stroke grid rasterizer core
// Turns touch strokes into a marked cell grid and reads grid rows back.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A read item returns its
// row one cycle later: done is high for exactly one cycle with row_number and
// row_bits, and the receiver must take that beat then, since it cannot stall
// the core. Read, release, clear and out-of-area items leave busy low, so a
// new item can follow on the next cycle. A press inside the drawing area
// draws a line from the slot's last point (from the touch point itself if
// the slot has none) and raises busy until the final pixel is marked: the
// setup and rem states turn the start point into a cell and an in-cell
// offset, then the pixel loop steps along the larger of |dx| and |dy| in
// pixels, one point per cycle, which sets the rate. The default drawing area
// spans 336 pixels. The clear zone register may be written in any idle cycle.
// ----------------------------------------------------------------------------
module touch_stroke_grid_rasterizer_core
  import tsgr_pkg::*;
#(
  parameter int GRID_CELLS  = GridCellsDef,
  parameter int CELL_PIXELS = CellPixelsDef,
  parameter int AREA_ORIGIN = AreaOriginDef,
  parameter int TOUCH_SLOTS = TouchSlotsDef
) (
  input  logic                clk,
  input  logic                rst,
  // Item channel.
  input  logic                start,
  output logic                busy,
  input  logic                action,
  input  logic [SlotW-1:0]    slot,
  input  logic                pressed,
  input  logic [CoordW-1:0]   touch_x,
  input  logic [CoordW-1:0]   touch_y,
  input  logic [RowSelW-1:0]  row_select,
  // Result channel.
  output logic                done,
  output logic [RowSelW-1:0]  row_number,
  output logic [RowBitsW-1:0] row_bits,
  // Clear zone register write port.
  input  logic                cfg_wr_en,
  input  logic [CoordW-1:0]   cfg_wr_data
);

  // The controller only sequences; all state that the items see lives in the
  // datapath, which reports whether the item on the inputs starts a line and
  // when the line's final pixel is being marked.
  tsgr_cmd_t  cmd;
  tsgr_stat_t stat;

  tsgr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  tsgr_datapath #(
    .GRID_CELLS  (GRID_CELLS),
    .CELL_PIXELS (CELL_PIXELS),
    .AREA_ORIGIN (AREA_ORIGIN),
    .TOUCH_SLOTS (TOUCH_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .action      (action),
    .slot        (slot),
    .pressed     (pressed),
    .touch_x     (touch_x),
    .touch_y     (touch_y),
    .row_select  (row_select),
    .done        (done),
    .row_number  (row_number),
    .row_bits    (row_bits)
  );

endmodule
